>>> sv/ajf_pkg.sv
package ajf_pkg;

	localparam int ACC_W     = 12;
	localparam int DIFF_W    = ACC_W + 1;
	localparam int SCALE_W   = 16;
	localparam int DT_W      = 16;
	localparam int JERK_W    = 16;
	localparam int FACE_W    = 3;
	localparam int PROD_W    = ACC_W + SCALE_W;
	localparam int REM_W     = DT_W + 1;
	// two quotient bits per divider cycle
	localparam int DIV_STEPS = PROD_W / 2;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;
	// register index is paddr[2]
	localparam logic REG_SCALE = 1'b0;

	localparam logic [FACE_W-1:0] FACE_PZ = 3'd0;
	localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NX = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
	} lane_ctrl_t;

endpackage

>>> sv/ajf_lane.sv
module ajf_lane
	import ajf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  lane_ctrl_t                ctrl,
	input  logic signed [DIFF_W-1:0]  diff,
	input  logic        [DT_W-1:0]    den,
	input  logic                      dt_neg,
	input  logic        [SCALE_W-1:0] scale,
	output logic        [PROD_W-1:0]  quo,
	output logic                      neg
);

	logic [ACC_W-1:0]  mag_q;
	logic              neg_q;
	logic [DT_W-1:0]   den_q;
	logic [PROD_W-1:0] num_q;
	logic [REM_W-1:0]  rem_q;

	logic [ACC_W-1:0]  diff_abs;
	logic [PROD_W-1:0] num_nxt;
	logic [REM_W-1:0]  rem_nxt;

	// |diff| is at most 4095, so it fits the sample width
	assign diff_abs = diff[DIFF_W-1] ? ACC_W'(-diff) : ACC_W'(diff);

	// restoring shift-subtract, two bits per cycle; quotient shifts into num
	always_comb begin
		logic [REM_W-1:0]  r;
		logic [PROD_W-1:0] n;
		r = rem_q;
		n = num_q;
		for (int i = 0; i < 2; i++) begin
			r = {r[DT_W-1:0], n[PROD_W-1]};
			if (r >= {1'b0, den_q}) begin
				r = r - {1'b0, den_q};
				n = {n[PROD_W-2:0], 1'b1};
			end else begin
				n = {n[PROD_W-2:0], 1'b0};
			end
		end
		rem_nxt = r;
		num_nxt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
		end else if (ctrl.load) begin
			neg_q <= diff[DIFF_W-1] ^ dt_neg;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= diff_abs;
			den_q <= den;
		end
		if (ctrl.mul) begin
			num_q <= PROD_W'(mag_q) * PROD_W'(scale);
			rem_q <= '0;
		end else if (ctrl.step) begin
			num_q <= num_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quo = num_q;
	assign neg = neg_q;

endmodule

>>> sv/ajf_merge.sv
module ajf_merge
	import ajf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     capture,
	input  logic [PROD_W-1:0]        quo_x,
	input  logic                     neg_x,
	input  logic [PROD_W-1:0]        quo_y,
	input  logic                     neg_y,
	input  logic [PROD_W-1:0]        quo_z,
	input  logic                     neg_z,
	input  logic [FACE_W-1:0]        face,
	input  logic                     zero,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [JERK_W-1:0] jerk_x,
	output logic signed [JERK_W-1:0] jerk_y,
	output logic signed [JERK_W-1:0] jerk_z,
	output logic [FACE_W-1:0]        up_face,
	output logic                     zero_interval
);

	localparam logic [PROD_W-1:0] POS_LIM = PROD_W'({1'b0, {(JERK_W-1){1'b1}}});
	localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'({1'b1, {(JERK_W-1){1'b0}}});
	localparam logic [JERK_W-1:0] J_MAX   = {1'b0, {(JERK_W-1){1'b1}}};
	localparam logic [JERK_W-1:0] J_MIN   = {1'b1, {(JERK_W-1){1'b0}}};

	function automatic logic [JERK_W-1:0] sat_jerk(input logic [PROD_W-1:0] q,
			input logic n, input logic z);
		logic [JERK_W-1:0] res;
		if (z) begin
			res = '0;
		end else if (!n) begin
			res = (q > POS_LIM) ? J_MAX : q[JERK_W-1:0];
		end else begin
			res = (q > NEG_LIM) ? J_MIN : JERK_W'(-q[JERK_W-1:0]);
		end
		return res;
	endfunction

	logic                     valid_q;
	logic signed [JERK_W-1:0] jx_q, jy_q, jz_q;
	logic [FACE_W-1:0]        face_q;
	logic                     zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (capture) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			jx_q   <= sat_jerk(quo_x, neg_x, zero);
			jy_q   <= sat_jerk(quo_y, neg_y, zero);
			jz_q   <= sat_jerk(quo_z, neg_z, zero);
			face_q <= face;
			zero_q <= zero;
		end
	end

	assign out_valid     = valid_q;
	assign jerk_x        = jx_q;
	assign jerk_y        = jy_q;
	assign jerk_z        = jz_q;
	assign up_face       = face_q;
	assign zero_interval = zero_q;

endmodule

>>> sv/accel_jerk_and_face.sv
// Jerk and up-face detector for one 3-axis accelerometer sample per input beat. Each
// sample is compared with the previous one (zero after reset); per axis the jerk is
// (sample - previous) * scale / dt, dt being the low 16 bits of the timestamp
// difference read as signed, truncated toward zero and clamped to signed 16 bits. A zero
// dt gives zero jerk and sets zero_interval. The up face comes from the largest-magnitude
// axis and its sign. An accepted beat passes these steps: the differences and divisor
// are loaded at the input beat, then the scale multiply, then the per-axis shift-subtract
// divider (28 quotient bits, two a cycle), then the move into the output register, which
// waits while out_stall holds a previous result there. The three axis lanes run in
// lockstep; in_stall stays high until the result has moved into the output register,
// which may still be waiting on out_stall while the next sample is taken. The 16-bit
// scale register sits at byte address 0 of the APB port; the user must write it only
// while idle, as the block itself does not enforce this.
module accel_jerk_and_face
	import ajf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ACC_W-1:0]  accel_x,
	input  logic signed [ACC_W-1:0]  accel_y,
	input  logic signed [ACC_W-1:0]  accel_z,
	input  logic [31:0]              time_ms,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [JERK_W-1:0] jerk_x,
	output logic signed [JERK_W-1:0] jerk_y,
	output logic signed [JERK_W-1:0] jerk_z,
	output logic [FACE_W-1:0]        up_face,
	output logic                     zero_interval
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SCALE_W-1:0] scale_q;
	logic [ACC_W-1:0]   prev_x_q, prev_y_q, prev_z_q;
	logic [DT_W-1:0]    prev_time_q;
	logic [FACE_W-1:0]  face_q;
	logic               zero_q;

	logic               accept;
	logic               capture;
	lane_ctrl_t         ctrl;
	logic [DT_W-1:0]    dt;
	logic [DT_W-1:0]    den;
	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic [ACC_W-1:0]   ax, ay, az;
	logic [FACE_W-1:0]  face;
	logic [PROD_W-1:0]  quo_x, quo_y, quo_z;
	logic               neg_x, neg_y, neg_z;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SCALE) ? DATA_W'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_SCALE) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign capture  = (state_q == ST_FIN) && (!out_valid || !out_stall);

	assign dt  = time_ms[DT_W-1:0] - prev_time_q;
	assign den = dt[DT_W-1] ? DT_W'(-dt) : dt;
	assign dx  = {accel_x[ACC_W-1], accel_x} - {prev_x_q[ACC_W-1], prev_x_q};
	assign dy  = {accel_y[ACC_W-1], accel_y} - {prev_y_q[ACC_W-1], prev_y_q};
	assign dz  = {accel_z[ACC_W-1], accel_z} - {prev_z_q[ACC_W-1], prev_z_q};

	// magnitudes as unsigned; -2048 maps to 2048
	assign ax = accel_x[ACC_W-1] ? ACC_W'(-accel_x) : ACC_W'(accel_x);
	assign ay = accel_y[ACC_W-1] ? ACC_W'(-accel_y) : ACC_W'(accel_y);
	assign az = accel_z[ACC_W-1] ? ACC_W'(-accel_z) : ACC_W'(accel_z);

	always_comb begin
		if (ax > ay) begin
			if (ax > az) begin
				face = (!accel_x[ACC_W-1] && accel_x != 0) ? FACE_PX : FACE_NX;
			end else begin
				face = (!accel_z[ACC_W-1] && accel_z != 0) ? FACE_PZ : FACE_NZ;
			end
		end else if (az > ay) begin
			face = (!accel_z[ACC_W-1] && accel_z != 0) ? FACE_PZ : FACE_NZ;
		end else begin
			face = (!accel_y[ACC_W-1] && accel_y != 0) ? FACE_PY : FACE_NY;
		end
	end

	assign ctrl = '{load: accept, mul: (state_q == ST_MUL), step: (state_q == ST_DIV)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			prev_time_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_MUL;
						prev_x_q    <= accel_x;
						prev_y_q    <= accel_y;
						prev_z_q    <= accel_z;
						prev_time_q <= time_ms[DT_W-1:0];
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_FIN: begin
					if (capture) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			face_q <= face;
			zero_q <= (dt == '0);
		end
	end

	ajf_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.diff   (dx),
		.den    (den),
		.dt_neg (dt[DT_W-1]),
		.scale  (scale_q),
		.quo    (quo_x),
		.neg    (neg_x)
	);

	ajf_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.diff   (dy),
		.den    (den),
		.dt_neg (dt[DT_W-1]),
		.scale  (scale_q),
		.quo    (quo_y),
		.neg    (neg_y)
	);

	ajf_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.diff   (dz),
		.den    (den),
		.dt_neg (dt[DT_W-1]),
		.scale  (scale_q),
		.quo    (quo_z),
		.neg    (neg_z)
	);

	ajf_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.capture       (capture),
		.quo_x         (quo_x),
		.neg_x         (neg_x),
		.quo_y         (quo_y),
		.neg_y         (neg_y),
		.quo_z         (quo_z),
		.neg_z         (neg_z),
		.face          (face_q),
		.zero          (zero_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.jerk_x        (jerk_x),
		.jerk_y        (jerk_y),
		.jerk_z        (jerk_z),
		.up_face       (up_face),
		.zero_interval (zero_interval)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after accepted beat");

	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result presented without finished divide");

	a_zero_jerk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_interval |-> jerk_x == 0 && jerk_y == 0 && jerk_z == 0)
		else $error("nonzero jerk on zero interval");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> up_face <= FACE_NZ)
		else $error("up face out of range");

endmodule
